// ----- hw/rtl/afe_pkg.sv -----
// Package for the API frame encoder: frame constants, the item and beat
// structs passed between modules, and the header byte lookup.
// No dependencies.
`timescale 1ns / 1ps

package afe_pkg;

   // Input command codes (carried in req_tuser)
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   // Frame kinds
   localparam logic KIND_TX_REQ   = 1'b0;
   localparam logic KIND_BT_RELAY = 1'b1;

   // Payload length limit; start lengths above it are clipped
   localparam logic [7:0] PAYLOAD_MAX = 8'd255;

   // Frame byte constants
   localparam logic [7:0] START_DELIM   = 8'h7E;
   localparam logic [7:0] TYPE_TX_REQ   = 8'h10;
   localparam logic [7:0] TYPE_BT_RELAY = 8'h2D;
   localparam logic [7:0] ADDR16_HI     = 8'hFF;
   localparam logic [7:0] ADDR16_LO     = 8'hFE;
   localparam logic [7:0] IFACE_BT      = 8'h01;
   localparam logic [7:0] BYTE_ZERO     = 8'h00;
   localparam logic [7:0] CHK_BASE      = 8'hFF;

   // Length field overhead per kind
   localparam logic [15:0] LEN_OVH_TX = 16'd14;
   localparam logic [15:0] LEN_OVH_BT = 16'd3;

   // Checksummed header bytes, summed mod 256 per kind
   localparam logic [7:0] HSUM_TX = 8'(TYPE_TX_REQ + ADDR16_HI + ADDR16_LO);
   localparam logic [7:0] HSUM_BT = 8'(TYPE_BT_RELAY + IFACE_BT);

   // Header sizes in bytes
   localparam logic [4:0] HDR_BYTES_TX = 5'd17;
   localparam logic [4:0] HDR_BYTES_BT = 5'd6;

   // One accepted item, ready for byte emission
   typedef struct packed {
      logic        cmd;
      logic        kind;
      logic [15:0] len;
      logic [7:0]  data;
      logic        chk_en;
      logic [7:0]  chk_val;
   } item_type;

   // One result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_done;
   } beat_type;

   // Header byte at position idx for the given kind and length field
   function automatic logic [7:0] hdr_byte(input logic kind, input logic [15:0] len,
                                           input logic [4:0] idx);
      logic [7:0] b;
      b = BYTE_ZERO;
      if (kind == KIND_TX_REQ) begin
         case (idx)
            5'd0:    b = START_DELIM;
            5'd1:    b = len[15:8];
            5'd2:    b = len[7:0];
            5'd3:    b = TYPE_TX_REQ;
            5'd13:   b = ADDR16_HI;
            5'd14:   b = ADDR16_LO;
            default: b = BYTE_ZERO;
         endcase
      end else begin
         case (idx)
            5'd0:    b = START_DELIM;
            5'd1:    b = len[15:8];
            5'd2:    b = len[7:0];
            5'd3:    b = TYPE_BT_RELAY;
            5'd5:    b = IFACE_BT;
            default: b = BYTE_ZERO;
         endcase
      end
      return b;
   endfunction

endpackage

// ----- hw/rtl/afe_frame_state.sv -----
// Frame state of the API frame encoder: running sum, bytes left and open flag,
// updated per accepted transaction; builds the item descriptor.
// Depends on afe_pkg.
`timescale 1ns / 1ps

module afe_frame_state (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              cmd,
   input  logic              frame_kind,
   input  logic [7:0]        payload_length,
   input  logic [7:0]        data_byte,
   output logic              item_keep,
   output afe_pkg::item_type item
);
   import afe_pkg::*;

   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic       frame_open_ff, frame_open_in;

   logic [7:0] plen_sat;
   logic [7:0] hsum;
   logic [7:0] sum_next;
   logic [7:0] left_next;

   // Clip the announced length and pick the header sum
   assign plen_sat  = (payload_length > PAYLOAD_MAX) ? PAYLOAD_MAX : payload_length;
   assign hsum      = (frame_kind == KIND_TX_REQ) ? HSUM_TX : HSUM_BT;
   assign sum_next  = 8'(running_sum_ff + data_byte);
   assign left_next = 8'(bytes_left_ff - 8'd1);

   // Build the descriptor and the next state
   always_comb begin
      running_sum_in = running_sum_ff;
      bytes_left_in  = bytes_left_ff;
      frame_open_in  = frame_open_ff;
      item.cmd       = cmd;
      item.kind      = frame_kind;
      item.len       = (frame_kind == KIND_TX_REQ) ? (16'(plen_sat) + LEN_OVH_TX)
                                                   : (16'(plen_sat) + LEN_OVH_BT);
      item.data      = data_byte;
      item.chk_en    = 1'b0;
      item.chk_val   = 8'(CHK_BASE - hsum);
      item_keep      = 1'b0;
      if (cmd == CMD_START) begin
         item_keep   = 1'b1;
         item.chk_en = (plen_sat == 8'd0);
         if (accept) begin
            running_sum_in = hsum;
            bytes_left_in  = plen_sat;
            frame_open_in  = (plen_sat != 8'd0);
         end
      end else if (frame_open_ff) begin
         item_keep    = 1'b1;
         item.chk_en  = (left_next == 8'd0);
         item.chk_val = 8'(CHK_BASE - sum_next);
         if (accept) begin
            running_sum_in = sum_next;
            bytes_left_in  = left_next;
            frame_open_in  = (left_next != 8'd0);
         end
      end
   end

   // Hold the frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= 8'd0;
         bytes_left_ff  <= 8'd0;
         frame_open_ff  <= 1'b0;
      end else begin
         running_sum_ff <= running_sum_in;
         bytes_left_ff  <= bytes_left_in;
         frame_open_ff  <= frame_open_in;
      end
   end

   // An open frame always has payload bytes outstanding
   a_open_has_left: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff |-> (bytes_left_ff != 8'd0))
      else $error("frame open with no bytes left");

endmodule

// ----- hw/rtl/afe_byte_seq.sv -----
// Byte sequencer of the API frame encoder: holds the current item and steps
// through its header, payload and checksum bytes, one per cycle while out_ready
// is high. Depends on afe_pkg.
`timescale 1ns / 1ps

module afe_byte_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  afe_pkg::item_type item,
   input  logic              out_ready,
   output logic              load_ready,
   output logic              emit,
   output afe_pkg::beat_type beat
);
   import afe_pkg::*;

   item_type   cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [4:0] idx_ff, idx_in;

   logic [4:0] body_bytes;
   logic [4:0] total_bytes;
   logic       last_byte;
   logic       done;

   // Count the bytes this item produces
   always_comb begin
      if (cur_ff.cmd == CMD_START) begin
         body_bytes = (cur_ff.kind == KIND_TX_REQ) ? HDR_BYTES_TX : HDR_BYTES_BT;
      end else begin
         body_bytes = 5'd1;
      end
      total_bytes = body_bytes + 5'(cur_ff.chk_en);
   end

   assign last_byte  = (idx_ff == 5'(total_bytes - 5'd1));
   assign emit       = cur_valid_ff && out_ready;
   assign done       = emit && last_byte;
   assign load_ready = !cur_valid_ff || done;

   // Select the byte at the current position
   always_comb begin
      beat.run_last   = last_byte;
      beat.frame_done = (idx_ff >= body_bytes);
      if (idx_ff >= body_bytes) begin
         beat.out_byte = cur_ff.chk_val;
      end else if (cur_ff.cmd == CMD_START) begin
         beat.out_byte = hdr_byte(cur_ff.kind, cur_ff.len, idx_ff);
      end else begin
         beat.out_byte = cur_ff.data;
      end
   end

   // Advance position, load the next item
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_in       = item;
         cur_valid_in = 1'b1;
         idx_in       = 5'd0;
      end else if (done) begin
         cur_valid_in = 1'b0;
         idx_in       = 5'd0;
      end else if (emit) begin
         idx_in = 5'(idx_ff + 5'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 5'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
      cur_ff <= cur_in;
   end

   // Position stays within the item
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (idx_ff < total_bytes))
      else $error("byte position beyond item");

   // Loads happen only when the slot frees up
   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      load |-> load_ready)
      else $error("item loaded over a busy slot");

   // Finishing an item without a new load empties the slot
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (done && !load) |=> !cur_valid_ff)
      else $error("slot still busy after last byte");

endmodule

// ----- hw/rtl/afe_out_reg.sv -----
// Result register of the API frame encoder: holds one beat until the
// downstream side takes it. Depends on afe_pkg.
`timescale 1ns / 1ps

module afe_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              emit,
   input  afe_pkg::beat_type beat,
   output logic              out_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);
   import afe_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff, beat_in;

   assign out_ready = !valid_ff || rsp_tready;

   // Load a new beat or drop the taken one
   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff;
      if (emit) begin
         beat_in  = beat;
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = beat_ff.out_byte;
   assign rsp_tlast  = beat_ff.run_last;
   assign rsp_tuser  = beat_ff.frame_done;

endmodule

// ----- hw/rtl/api_frame_encoder.sv -----
// API frame encoder top level. Depends on afe_pkg, afe_frame_state,
// afe_byte_seq and afe_out_reg.
`timescale 1ns / 1ps

// Wraps a payload into radio-module API frames on a byte stream. A start
// transaction (req_tuser = 0) emits the frame header: 17 bytes for a transmit
// request, 6 for a data relay, plus the checksum at once when the payload
// length is zero. Each payload transaction (req_tuser = 1) emits its byte, and
// the last announced byte is followed by the checksum. rsp_tlast marks the
// final byte caused by one input transaction; rsp_tuser marks the checksum.
// Payload bytes outside a frame are dropped; a start abandons an open frame.
// The output runs at one byte per cycle while rsp_tready stays high, set by
// the single result register. A new transaction is taken in the cycle the
// previous one emits its last byte.
module api_frame_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [0] frame_kind, [8:1] payload_length,
                                   // [16:9] data_byte, [23:17] zero
   input  logic        req_tuser,  // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] out_byte
   output logic        rsp_tlast,  // run_last
   output logic        rsp_tuser   // [0] frame_done
);
   import afe_pkg::*;

   logic     accept;
   logic     item_keep;
   item_type item;
   logic     load_ready;
   logic     out_ready;
   logic     emit;
   beat_type beat;

   assign req_tready = load_ready;
   assign accept     = req_tvalid && load_ready;

   // Frame state and item descriptor
   afe_frame_state u_state (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .cmd            (req_tuser),
      .frame_kind     (req_tdata[0]),
      .payload_length (req_tdata[8:1]),
      .data_byte      (req_tdata[16:9]),
      .item_keep      (item_keep),
      .item           (item)
   );

   // Byte sequencer
   afe_byte_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && item_keep),
      .item       (item),
      .out_ready  (out_ready),
      .load_ready (load_ready),
      .emit       (emit),
      .beat       (beat)
   );

   // Result register
   afe_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .beat       (beat),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
